// ===== hw/rtl/rfw_pkg.sv =====
// rotated framebuffer writer: shared types, sizes, codes and helper functions
// no dependencies; every other file imports this package
`timescale 1ns / 1ps
`default_nettype none

package rfw_pkg;

    localparam int MEM_DEPTH = 16384;
    localparam int MAX_DIM   = 256;

    localparam int ADDR_W   = $clog2(MEM_DEPTH);
    localparam int DIM_W    = 9;
    localparam int COORD_W  = 8;
    localparam int COLOUR_W = 16;
    localparam int RADDR_W  = 14;
    localparam int OP_W     = 2;
    localparam int ACC_W    = 2 * DIM_W;
    localparam int CNT_W    = $clog2(DIM_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [COLOUR_W-1:0] RESET_COLOUR = 16'hF81F;

    localparam int MIRROR_H = 0;
    localparam int MIRROR_V = 1;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION = 2'd0,
        CFG_MIRROR   = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]       rotation;
        logic [1:0]       mirror_mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  y_coord;
        logic [COLOUR_W-1:0] pixel_color;
        logic [RADDR_W-1:0]  read_address;
    } cmd_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] read_data;
        logic [RADDR_W-1:0]  written_address;
        logic                written;
        logic                clipped;
    } rsp_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [COLOUR_W-1:0] wdata;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic idle;
        logic filling;
        logic res_load;
    } ctrl_status_t;

    // dimensions above the display limit behave as the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        if (int'(d) > MAX_DIM)
            return DIM_W'(MAX_DIM);
        return d;
    endfunction

    function automatic logic [COLOUR_W-1:0] swap_bytes(input logic [COLOUR_W-1:0] c);
        return {c[7:0], c[15:8]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rfw_cmd_if.sv =====
// request channel into the framebuffer writer: valid/ready plus request fields
// depends on rfw_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface rfw_cmd_if;
    import rfw_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic [COLOUR_W-1:0] pixel_color;
    logic [RADDR_W-1:0]  read_address;

    modport source (
        output valid, operation, x_coord, y_coord, pixel_color, read_address,
        input  ready
    );

    modport sink (
        input  valid, operation, x_coord, y_coord, pixel_color, read_address,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/rfw_rsp_if.sv =====
// result channel out of the framebuffer writer: valid/ready plus result fields
// depends on rfw_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface rfw_rsp_if;
    import rfw_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLOUR_W-1:0] read_data;
    logic [RADDR_W-1:0]  written_address;
    logic                written;
    logic                clipped;

    modport source (
        output valid, read_data, written_address, written, clipped,
        input  ready
    );

    modport sink (
        input  valid, read_data, written_address, written, clipped,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/rfw_alu.sv =====
// shared adder used for the shift-add multiply steps and the sweep address count
// depends on rfw_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfw_alu
    import rfw_pkg::*;
(
    input  wire logic [ACC_W-1:0] a,
    input  wire logic [ACC_W-1:0] b,
    output logic      [ACC_W-1:0] sum
);

    assign sum = a + b;

endmodule

`default_nettype wire

// ===== hw/rtl/rfw_store.sv =====
// frame store: one write port, one read port with registered read data
// depends on rfw_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfw_store
    import rfw_pkg::*;
(
    input  wire logic                clk,
    input  wire mem_req_t            req,
    output logic      [COLOUR_W-1:0] q
);

    logic [COLOUR_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        q <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfw_ctrl.sv =====
// sequencer: coordinate mapping, shift-add address multiply, fill sweep, reads
// depends on rfw_pkg and rfw_alu
`timescale 1ns / 1ps
`default_nettype none

module rfw_ctrl
    import rfw_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                cmd_valid,
    input  wire cmd_t                cmd,
    output logic                     cmd_ready,
    input  wire logic                out_free,
    output rsp_t                     res,
    output ctrl_status_t             status,
    output mem_req_t                 mem_req,
    input  wire logic [COLOUR_W-1:0] mem_q
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_PLACE = 7'b0000100,
        S_AREA  = 7'b0001000,
        S_FILL  = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic [DIM_W-1:0]    mplier_reg, mplier_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ACC_W-1:0]    fill_addr_reg, fill_addr_next;
    logic [COLOUR_W-1:0] colour_reg, colour_next;
    logic                init_reg, init_next;
    logic                rd_ok_reg, rd_ok_next;
    rsp_t                res_reg, res_next;

    logic [ACC_W-1:0] alu_a, alu_b, alu_sum;

    logic [DIM_W-1:0] w, h, pw, ph, x9, y9, xsel, ysel, px, py;
    logic             odd, in_range, flip_x, flip_y, last_step, fill_end;

    rfw_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum)
    );

    // map logical coordinates to memory column and row
    always_comb
    begin
        w        = eff_dim(cfg.width);
        h        = eff_dim(cfg.height);
        odd      = cfg.rotation[0];
        pw       = odd ? h : w;
        ph       = odd ? w : h;
        x9       = DIM_W'(cmd.x_coord);
        y9       = DIM_W'(cmd.y_coord);
        in_range = (x9 < w) && (y9 < h);
        xsel     = odd ? y9 : x9;
        ysel     = odd ? x9 : y9;
        flip_x   = ((cfg.rotation == ROT_90) || (cfg.rotation == ROT_180))
                   ^ cfg.mirror_mode[MIRROR_H];
        flip_y   = ((cfg.rotation == ROT_180) || (cfg.rotation == ROT_270))
                   ^ cfg.mirror_mode[MIRROR_V];
        px       = flip_x ? (pw - xsel - DIM_W'(1)) : xsel;
        py       = flip_y ? (ph - ysel - DIM_W'(1)) : ysel;
    end

    assign last_step = (cnt_reg == CNT_W'(DIM_W - 1));
    assign fill_end  = (fill_addr_reg == acc_reg) || (fill_addr_reg == ACC_W'(MEM_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        fill_addr_next = fill_addr_reg;
        colour_next    = colour_reg;
        init_next      = init_reg;
        rd_ok_next     = rd_ok_reg;
        res_next       = res_reg;
        alu_a          = acc_reg;
        alu_b          = '0;
        mem_req.we     = 1'b0;
        mem_req.waddr  = acc_reg[ADDR_W-1:0];
        mem_req.wdata  = colour_reg;
        mem_req.raddr  = ADDR_W'(cmd.read_address);
        status.idle     = (state_reg == S_IDLE);
        status.filling  = (state_reg == S_FILL);
        status.res_load = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_next    = '0;
                    cnt_next    = '0;
                    case (cmd.operation)
                        OP_SET:
                        begin
                            if (!in_range)
                            begin
                                res_next.clipped = 1'b1;
                                state_next       = S_DONE;
                            end
                            else
                            begin
                                acc_next    = ACC_W'(px);
                                mcand_next  = ACC_W'(pw);
                                mplier_next = py;
                                colour_next = swap_bytes(cmd.pixel_color);
                                state_next  = S_MUL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            acc_next    = '0;
                            mcand_next  = ACC_W'(w);
                            mplier_next = h;
                            colour_next = cmd.pixel_color;
                            state_next  = S_AREA;
                        end
                        OP_READ:
                        begin
                            rd_ok_next = (int'(cmd.read_address) < MEM_DEPTH);
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL, S_AREA:
            begin
                // one partial product per cycle, lsb of the multiplier first
                alu_b       = mplier_reg[0] ? mcand_reg : '0;
                acc_next    = alu_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    fill_addr_next = '0;
                    state_next     = (state_reg == S_MUL) ? S_PLACE : S_FILL;
                end
            end
            S_PLACE:
            begin
                if (acc_reg < ACC_W'(MEM_DEPTH))
                begin
                    mem_req.we               = 1'b1;
                    res_next.written         = 1'b1;
                    res_next.written_address = RADDR_W'(acc_reg);
                end
                else
                begin
                    res_next.clipped = 1'b1;
                end
                state_next = S_DONE;
            end
            S_FILL:
            begin
                // acc holds the entry count; the sweep also stops at the store depth
                if (fill_end)
                begin
                    init_next  = 1'b0;
                    res_next   = '0;
                    state_next = init_reg ? S_IDLE : S_DONE;
                end
                else
                begin
                    mem_req.we     = 1'b1;
                    mem_req.waddr  = fill_addr_reg[ADDR_W-1:0];
                    alu_a          = fill_addr_reg;
                    alu_b          = ACC_W'(1);
                    fill_addr_next = alu_sum;
                end
            end
            S_READ:
            begin
                res_next.read_data = rd_ok_reg ? mem_q : '0;
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    status.res_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // after reset the whole store is swept to the reset colour
            state_reg     <= S_FILL;
            acc_reg       <= ACC_W'(MEM_DEPTH);
            fill_addr_reg <= '0;
            colour_reg    <= RESET_COLOUR;
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            fill_addr_reg <= fill_addr_next;
            colour_reg    <= colour_next;
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rd_ok_reg  <= rd_ok_next;
        res_reg    <= res_next;
    end

    assign cmd_ready      = (state_reg == S_IDLE);
    assign res            = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rotated_framebuffer_writer.sv =====
// one request at a time: a set pixel, a read or a clear runs to its result, and a clear
// writes width*height entries (capped at the store depth); the next request is taken
// once the result is handed on; the shared adder does the multiply as shift-add steps
// and the single write port sets the clear sweep at one entry per cycle
// reset: config returns to 0 deg, no mirror, 128 x 128; then a sweep over all 16384
// entries writes the reset colour into each while no request is taken
`timescale 1ns / 1ps
`default_nettype none

module rotated_framebuffer_writer
    import rfw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    rfw_cmd_if.sink                   cmd,
    rfw_rsp_if.source                 rsp
);

    cfg_t         cfg_reg;
    cmd_t         cmd_data;
    rsp_t         res;
    rsp_t         rsp_data_reg;
    logic         rsp_valid_reg;
    logic         out_free;
    ctrl_status_t status;
    mem_req_t     mem_req;
    logic [COLOUR_W-1:0] mem_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation    <= '0;
            cfg_reg.mirror_mode <= '0;
            cfg_reg.width       <= DIM_W'(128);
            cfg_reg.height      <= DIM_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROTATION: cfg_reg.rotation    <= cfg_data[1:0];
                CFG_MIRROR:   cfg_reg.mirror_mode <= cfg_data[1:0];
                CFG_WIDTH:    cfg_reg.width       <= cfg_data;
                CFG_HEIGHT:   cfg_reg.height      <= cfg_data;
                default:      cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cmd_data.operation    = cmd.operation;
    assign cmd_data.x_coord      = cmd.x_coord;
    assign cmd_data.y_coord      = cmd.y_coord;
    assign cmd_data.pixel_color  = cmd.pixel_color;
    assign cmd_data.read_address = cmd.read_address;

    // output register frees the sequencer while a result waits
    assign out_free = !rsp_valid_reg || rsp.ready;

    rfw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd.valid),
        .cmd       (cmd_data),
        .cmd_ready (cmd.ready),
        .out_free  (out_free),
        .res       (res),
        .status    (status),
        .mem_req   (mem_req),
        .mem_q     (mem_q)
    );

    rfw_store u_store (
        .clk (clk),
        .req (mem_req),
        .q   (mem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (status.res_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.res_load)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.read_data       = rsp_data_reg.read_data;
    assign rsp.written_address = rsp_data_reg.written_address;
    assign rsp.written         = rsp_data_reg.written;
    assign rsp.clipped         = rsp_data_reg.clipped;

    a_no_request_during_sweep: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.filling |-> !cmd.ready
    ) else $error("request taken during a fill sweep");

    a_busy_after_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready
    ) else $error("sequencer still ready after taking a request");

    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.res_load |-> (!rsp_valid_reg || rsp.ready)
    ) else $error("pending result overwritten");

    a_written_not_clipped: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.written && rsp.clipped)
    ) else $error("result both written and clipped");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for rotated_framebuffer_writer: directed table, then random phases under
// changing rotation, mirror and display size, each result checked against its table entry or a shadow store
// depends on rfw_pkg, rfw_cmd_if, rfw_rsp_if and the rtl top level
`timescale 1ns / 1ps

module tb_top;
    import rfw_pkg::*;

    localparam int RANDOM_REQUESTS = 700;
    localparam int PHASE_REQUESTS  = 40;
    localparam int WATCHDOG_LIMIT  = 80000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int REPORT_LIMIT    = 10;
    localparam int CLEAR_AREA_MAX  = 4096;
    localparam int RECENT_DEPTH    = 32;
    localparam rsp_t ALL_ZERO      = '0;
    localparam rsp_t CLIPPED       = '{16'h0000, 14'd0, 1'b0, 1'b1};

    typedef struct packed {
        logic             is_cfg;
        cfg_idx_t         reg_sel;
        logic [DIM_W-1:0] reg_val;
        cmd_t             req;
        logic             typed;
        rsp_t             want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_data;

    rfw_cmd_if cmd_ch ();
    rfw_rsp_if rsp_ch ();

    rotated_framebuffer_writer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    // shadow of the block's state
    logic [COLOUR_W-1:0] shadow_frame [MEM_DEPTH];
    cfg_t                shadow_cfg;
    rsp_t                pending_responses [$];
    int                  written_addrs [$];

    int  mismatch_count;
    int  results_checked;
    int  idle_cycles;
    int  n_set, n_stored, n_clipped, n_clear, n_read, n_unused;
    int  settings_used;
    int  random_sent;
    bit  no_stall;
    rsp_t got_rsp;
    rsp_t want_rsp;

    stim_row_t directed_rows [];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int visible_dim(input logic [DIM_W-1:0] d);
        return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic rsp_t predict_frame_response(input cmd_t c);
        rsp_t r;
        int   w, h, pw, ph, px, py, addr, fill;
        r = '0;
        w = visible_dim(shadow_cfg.width);
        h = visible_dim(shadow_cfg.height);
        case (op_t'(c.operation))
            OP_SET:
            begin
                if (int'(c.x_coord) >= w || int'(c.y_coord) >= h)
                    r.clipped = 1'b1;
                else
                begin
                    if (rot_t'(shadow_cfg.rotation) == ROT_0 ||
                        rot_t'(shadow_cfg.rotation) == ROT_180)
                    begin
                        pw = w;
                        ph = h;
                    end
                    else
                    begin
                        pw = h;
                        ph = w;
                    end
                    case (rot_t'(shadow_cfg.rotation))
                        ROT_0:
                        begin
                            px = int'(c.x_coord);
                            py = int'(c.y_coord);
                        end
                        ROT_90:
                        begin
                            px = pw - int'(c.y_coord) - 1;
                            py = int'(c.x_coord);
                        end
                        ROT_180:
                        begin
                            px = pw - int'(c.x_coord) - 1;
                            py = ph - int'(c.y_coord) - 1;
                        end
                        default:
                        begin
                            px = int'(c.y_coord);
                            py = ph - int'(c.x_coord) - 1;
                        end
                    endcase
                    if (shadow_cfg.mirror_mode[MIRROR_H])
                        px = pw - px - 1;
                    if (shadow_cfg.mirror_mode[MIRROR_V])
                        py = ph - py - 1;
                    addr = px + py * pw;
                    // a display bigger than the store spills past the end: treated as clipped
                    if (px >= pw || py >= ph || addr >= MEM_DEPTH)
                        r.clipped = 1'b1;
                    else
                    begin
                        shadow_frame[addr] = {c.pixel_color[7:0], c.pixel_color[15:8]};
                        r.written_address  = RADDR_W'(addr);
                        r.written          = 1'b1;
                        written_addrs.push_back(addr);
                        if (written_addrs.size() > RECENT_DEPTH)
                            void'(written_addrs.pop_front());
                    end
                end
            end
            OP_CLEAR:
            begin
                // clear keeps the colour unswapped
                fill = w * h;
                if (fill > MEM_DEPTH)
                    fill = MEM_DEPTH;
                for (int i = 0; i < fill; i++)
                    shadow_frame[i] = c.pixel_color;
            end
            OP_READ:
                r.read_data = shadow_frame[c.read_address];
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_idx_t sel, input int val);
        stim_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = DIM_W'(val);
        return r;
    endfunction

    function automatic stim_row_t req_row(input op_t op, input int x, input int y,
                                          input int colour, input int raddr,
                                          input bit typed, input rsp_t want);
        stim_row_t r;
        r                  = '0;
        r.req.operation    = op;
        r.req.x_coord      = COORD_W'(x);
        r.req.y_coord      = COORD_W'(y);
        r.req.pixel_color  = COLOUR_W'(colour);
        r.req.read_address = RADDR_W'(raddr);
        r.typed            = typed;
        r.want             = want;
        return r;
    endfunction

    function automatic cmd_t random_request();
        cmd_t c;
        int   w, h, pick;
        w = visible_dim(shadow_cfg.width);
        h = visible_dim(shadow_cfg.height);
        c.operation    = OP_READ;
        c.x_coord      = COORD_W'($urandom);
        c.y_coord      = COORD_W'($urandom);
        c.pixel_color  = COLOUR_W'($urandom);
        c.read_address = RADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            c.operation = OP_SET;
            // mostly on-screen, the rest anywhere in the coordinate range
            if (w > 0 && h > 0 && $urandom_range(0, 3) != 0)
            begin
                c.x_coord = COORD_W'($urandom_range(0, w - 1));
                c.y_coord = COORD_W'($urandom_range(0, h - 1));
            end
        end
        else if (pick < 60 && w * h <= CLEAR_AREA_MAX)
            c.operation = OP_CLEAR;
        else if (pick < 97)
        begin
            c.operation = OP_READ;
            if (written_addrs.size() > 0 && $urandom_range(0, 1) == 1)
                c.read_address = RADDR_W'(
                    written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
        end
        else
            c.operation = OP_NONE;
        return c;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return DIM_W'(1);
            1: return DIM_W'(MAX_DIM);
            2: return DIM_W'($urandom_range(MAX_DIM + 1, 511));
            3: return DIM_W'(0);
            default: return DIM_W'($urandom_range(2, 40));
        endcase
    endfunction

    task automatic send_request(input cmd_t c, input bit typed, input rsp_t want);
        rsp_t predicted;
        if (!no_stall && $urandom_range(0, 99) < 35)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid        <= 1'b1;
        cmd_ch.operation    <= c.operation;
        cmd_ch.x_coord      <= c.x_coord;
        cmd_ch.y_coord      <= c.y_coord;
        cmd_ch.pixel_color  <= c.pixel_color;
        cmd_ch.read_address <= c.read_address;
        forever
        begin
            @(posedge clk);
            if (cmd_ch.ready)
                break;
        end
        predicted = predict_frame_response(c);
        pending_responses.push_back(typed ? want : predicted);
        case (op_t'(c.operation))
            OP_SET:
            begin
                n_set++;
                if (predicted.written)
                    n_stored++;
                else
                    n_clipped++;
            end
            OP_CLEAR: n_clear++;
            OP_READ:  n_read++;
            default:  n_unused++;
        endcase
    endtask

    // drop the request line and let every outstanding result come back
    task automatic wait_idle();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t sel, input logic [DIM_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        case (sel)
            CFG_ROTATION: shadow_cfg.rotation    = val[1:0];
            CFG_MIRROR:   shadow_cfg.mirror_mode = val[1:0];
            CFG_WIDTH:    shadow_cfg.width       = val;
            default:      shadow_cfg.height      = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t %s: want data=%h addr=%0d wr=%b clip=%b, got data=%h addr=%0d wr=%b clip=%b",
                     $time, what, want.read_data, want.written_address, want.written,
                     want.clipped, got.read_data, got.written_address, got.written,
                     got.clipped);
    endtask

    // receiving side: random back-pressure on the result channel
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= no_stall || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_rsp = '{rsp_ch.read_data, rsp_ch.written_address, rsp_ch.written,
                        rsp_ch.clipped};
            results_checked++;
            if (pending_responses.size() == 0)
                note_failure("result with no request outstanding", ALL_ZERO, got_rsp);
            else
            begin
                want_rsp = pending_responses.pop_front();
                if (got_rsp.read_data !== want_rsp.read_data ||
                    got_rsp.written_address !== want_rsp.written_address ||
                    got_rsp.written !== want_rsp.written ||
                    got_rsp.clipped !== want_rsp.clipped)
                    note_failure("result mismatch", want_rsp, got_rsp);
            end
        end
    end

    // counts cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_responses.size());
                $display("end of test: mismatches");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_ROTATION;
        cfg_data            = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = OP_NONE;
        cmd_ch.x_coord      = '0;
        cmd_ch.y_coord      = '0;
        cmd_ch.pixel_color  = '0;
        cmd_ch.read_address = '0;
        no_stall            = 1'b0;
        mismatch_count      = 0;
        results_checked     = 0;
        idle_cycles         = 0;
        random_sent         = 0;
        settings_used       = 1;
        shadow_cfg          = '{ROT_0, 2'd0, DIM_W'(128), DIM_W'(128)};
        foreach (shadow_frame[i])
            shadow_frame[i] = RESET_COLOUR;

        directed_rows = '{
            // reset contents and first writes at both ends of the store
            req_row(OP_READ,  0,   0,   0,       0,     1, '{16'hF81F, 14'd0, 1'b0, 1'b0}),
            req_row(OP_READ,  0,   0,   0,       16383, 1, '{16'hF81F, 14'd0, 1'b0, 1'b0}),
            req_row(OP_SET,   0,   0,   'h1234,  0,     1, '{16'h0000, 14'd0, 1'b1, 1'b0}),
            req_row(OP_READ,  0,   0,   0,       0,     1, '{16'h3412, 14'd0, 1'b0, 1'b0}),
            req_row(OP_SET,   127, 127, 'hFFFF,  0,     1, '{16'h0000, 14'd16383, 1'b1, 1'b0}),
            // off-screen on either axis, then an unused code, a clear and reads
            req_row(OP_SET,   128, 0,   'h5A5A,  0,     1, CLIPPED),
            req_row(OP_SET,   0,   128, 'hA5A5,  0,     1, CLIPPED),
            req_row(OP_SET,   255, 255, 0,       16383, 1, CLIPPED),
            req_row(OP_NONE,  255, 255, 'hFFFF,  16383, 1, ALL_ZERO),
            req_row(OP_READ,  0,   0,   0,       16383, 1, '{16'hFFFF, 14'd0, 1'b0, 1'b0}),
            req_row(OP_CLEAR, 0,   0,   'h00FF,  0,     1, ALL_ZERO),
            req_row(OP_READ,  0,   0,   0,       16383, 1, '{16'h00FF, 14'd0, 1'b0, 1'b0}),
            req_row(OP_SET,   5,   3,   'hABCD,  0,     0, ALL_ZERO),
            req_row(OP_READ,  0,   0,   0,       389,   0, ALL_ZERO),
            // oversized width, display larger than the store
            cfg_row(CFG_WIDTH, 511),
            cfg_row(CFG_HEIGHT, MAX_DIM),
            req_row(OP_SET,   255, 63,  'h0102,  0,     1, '{16'h0000, 14'd16383, 1'b1, 1'b0}),
            req_row(OP_SET,   0,   64,  'h0304,  0,     1, CLIPPED),
            req_row(OP_CLEAR, 0,   0,   'h1357,  0,     1, ALL_ZERO),
            cfg_row(CFG_ROTATION, ROT_90),
            cfg_row(CFG_MIRROR, 3),
            req_row(OP_SET,   10,  200, 'h8001,  0,     0, ALL_ZERO),
            req_row(OP_SET,   255, 0,   'h7FFE,  0,     0, ALL_ZERO),
            // zero width: every pixel clipped, clear does nothing
            cfg_row(CFG_WIDTH, 0),
            req_row(OP_SET,   0,   0,   'hFFFF,  0,     1, CLIPPED),
            req_row(OP_CLEAR, 0,   0,   'hFFFF,  0,     1, ALL_ZERO),
            req_row(OP_READ,  0,   0,   0,       100,   0, ALL_ZERO),
            req_row(OP_READ,  0,   0,   0,       0,     0, ALL_ZERO)
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            else
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].want);
        end

        // random phases: all rotation and mirror pairs in turn, random display sizes
        while (random_sent < RANDOM_REQUESTS)
        begin
            write_reg(CFG_ROTATION, DIM_W'(settings_used % 4));
            write_reg(CFG_MIRROR, DIM_W'((settings_used / 4) % 4));
            write_reg(CFG_WIDTH, pick_dim());
            write_reg(CFG_HEIGHT, pick_dim());
            settings_used++;
            repeat (PHASE_REQUESTS)
            begin
                no_stall = (random_sent >= 280 && random_sent < 400);
                send_request(random_request(), 1'b0, ALL_ZERO);
                random_sent++;
            end
        end
        no_stall = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d pixel writes (%0d stored, %0d clipped), %0d clears, %0d reads, %0d unused",
                 n_set + n_clear + n_read + n_unused, n_set, n_stored, n_clipped, n_clear,
                 n_read, n_unused);
        $display("%0d display settings, %0d results checked, %0d failures",
                 settings_used, results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rfw_pkg.sv
hw/rtl/rfw_cmd_if.sv
hw/rtl/rfw_rsp_if.sv
hw/rtl/rfw_alu.sv
hw/rtl/rfw_store.sv
hw/rtl/rfw_ctrl.sv
hw/rtl/rotated_framebuffer_writer.sv
tb/sv/tb_top.sv
